FILE: hdl/tmi_pkg.sv
// ----------------------------------------------------------------------------
// tmi_pkg: shared constants and types
// Sizes, command codes, status codes and instruction characters of the
// tape machine interpreter.
// ----------------------------------------------------------------------------
package tmi_pkg;

  localparam int PROG_DEPTH  = 1024;
  localparam int TAPE_CELLS  = 256;
  localparam int STACK_DEPTH = 32;

  localparam int PA_W    = $clog2(PROG_DEPTH);      // program store index
  localparam int ADDR_W  = 11;                      // instr address / length
  localparam int DP_W    = $clog2(TAPE_CELLS);
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_STEP    = 2'd2;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_FINISHED = 3'd1;
  localparam logic [2:0] ST_UNM_CLS  = 3'd2;
  localparam logic [2:0] ST_UNM_OPN  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [7:0] OP_RIGHT = 8'h3E;  // >
  localparam logic [7:0] OP_LEFT  = 8'h3C;  // <
  localparam logic [7:0] OP_INC   = 8'h2B;  // +
  localparam logic [7:0] OP_DEC   = 8'h2D;  // -
  localparam logic [7:0] OP_OPEN  = 8'h5B;  // [
  localparam logic [7:0] OP_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] OP_IN    = 8'h2C;  // ,
  localparam logic [7:0] OP_OUT   = 8'h2E;  // .

  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic            clr;
    logic [DP_W-1:0] addr;
    logic [7:0]      wr_data;
  } tape_req_t;

endpackage

FILE: hdl/tmi_if.sv
// ----------------------------------------------------------------------------
// tmi_in_if / tmi_out_if: item channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface tmi_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [9:0] prog_addr;
  logic [7:0] prog_byte;
  logic [7:0] in_byte;

  modport source (output valid, cmd, prog_addr, prog_byte, in_byte, input ready);
  modport sink   (input valid, cmd, prog_addr, prog_byte, in_byte, output ready);
endinterface

interface tmi_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [2:0]  status;
  logic [10:0] next_addr;

  modport source (output valid, out_valid, out_byte, status, next_addr, input ready);
  modport sink   (input valid, out_valid, out_byte, status, next_addr, output ready);
endinterface

FILE: hdl/tmi_ram.sv
// ----------------------------------------------------------------------------
// tmi_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered and appears in the cycle after the request.
// ----------------------------------------------------------------------------
module tmi_ram #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/tmi_tape.sv
// ----------------------------------------------------------------------------
// tmi_tape: data tape memory
// Cell RAM with one valid bit per cell; a cell never written since reset or
// restart reads as zero. Clear drops all valid bits at once.
// ----------------------------------------------------------------------------
module tmi_tape (
  input  logic              clk,
  input  logic              rst_n,
  input  tmi_pkg::tape_req_t req,
  output logic [7:0]        rdata
);
  import tmi_pkg::*;

  logic [7:0]            mem [TAPE_CELLS];
  logic [TAPE_CELLS-1:0] valid_r;
  logic [7:0]            rdata_r;
  logic                  rvalid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvalid_r <= valid_r[req.addr];
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : 8'd0;

endmodule

FILE: hdl/tape_machine_interpreter_top.sv
// ----------------------------------------------------------------------------
// tape_machine_interpreter_top: eight-instruction tape machine
// Load, restart and step items; one registered result item per input item.
// A '[' on a zero cell starts a forward skip over the program bytes to the
// matching ']'; if no match is found before the program end, the result
// reports an unmatched open. A new item is accepted only while idle, after
// the registered read of the program, tape and loop stack memories, the
// write-back and the registering of the previous item's result.
// Reset clears pointers, loop depth, halt, program length and all tape valid
// bits at once; program store and loop stack are not cleared.
// ----------------------------------------------------------------------------
module tape_machine_interpreter_top (
  input  logic                    clk,
  input  logic                    rst_n,
  tmi_in_if.sink                  in_ch,
  tmi_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [tmi_pkg::ADDR_W-1:0] cfg_wdata
);
  import tmi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         cmd_r;
  logic [PA_W-1:0]    pa_r;
  logic [7:0]         pb_r, ib_r;
  logic [DP_W-1:0]    dp_r, dp_nxt;
  logic [ADDR_W-1:0]  ia_r, ia_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [2:0]         hcode_r, hcode_nxt;
  logic [ADDR_W-1:0]  len_r;
  logic [ADDR_W-1:0]  scan_r, scan_nxt;
  logic [ADDR_W-1:0]  nest_r, nest_nxt;

  logic               ovld_r, ovld_nxt;
  logic               oval_r, oval_nxt;
  logic [7:0]         obyte_r, obyte_nxt;
  logic [2:0]         ostat_r, ostat_nxt;
  logic [ADDR_W-1:0]  oaddr_r, oaddr_nxt;

  logic               can_emit, emit, step_done;
  logic [ADDR_W-1:0]  end_w;
  logic [2:0]         status_w;

  logic               prog_re, prog_we;
  logic [PA_W-1:0]    prog_raddr;
  logic [7:0]         prog_rdata;
  logic               stk_re, stk_we;
  logic [SP_W-1:0]    stk_raddr;
  logic [PA_W-1:0]    stk_rdata;
  tape_req_t          tape_req;
  logic [7:0]         cell_q;
  logic [DEPTH_W-1:0] depth_m1;

  assign end_w    = (len_r > ADDR_W'(PROG_DEPTH)) ? ADDR_W'(PROG_DEPTH) : len_r;
  assign can_emit = !ovld_r || out_ch.ready;
  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign in_ch.ready = (state_r == S_IDLE);

  tmi_ram #(.W(8), .D(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (pa_r),
    .wdata (pb_r),
    .re    (prog_re),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  tmi_ram #(.W(PA_W), .D(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[SP_W-1:0]),
    .wdata (ia_r[PA_W-1:0]),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  tmi_tape u_tape (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tape_req),
    .rdata (cell_q)
  );

  always_comb begin
    state_nxt  = state_r;
    dp_nxt     = dp_r;
    ia_nxt     = ia_r;
    depth_nxt  = depth_r;
    hcode_nxt  = hcode_r;
    scan_nxt   = scan_r;
    nest_nxt   = nest_r;
    emit       = 1'b0;
    step_done  = 1'b0;
    oval_nxt   = 1'b0;
    obyte_nxt  = 8'd0;
    prog_re    = 1'b0;
    prog_we    = 1'b0;
    prog_raddr = ia_r[PA_W-1:0];
    stk_re     = 1'b0;
    stk_we     = 1'b0;
    stk_raddr  = depth_m1[SP_W-1:0];
    tape_req.rd_en   = 1'b0;
    tape_req.wr_en   = 1'b0;
    tape_req.clr     = 1'b0;
    tape_req.addr    = dp_r;
    tape_req.wr_data = 8'd0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          prog_re        = 1'b1;
          stk_re         = 1'b1;
          tape_req.rd_en = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_emit) begin
          emit = 1'b1;
          case (cmd_r)
            CMD_LOAD: prog_we = 1'b1;
            CMD_RESTART: begin
              tape_req.clr = 1'b1;
              dp_nxt       = '0;
              ia_nxt       = '0;
              depth_nxt    = '0;
              hcode_nxt    = ST_RUN;
            end
            CMD_STEP: begin
              if (hcode_r == ST_RUN && ia_r < end_w) begin
                step_done = 1'b1;
                ia_nxt    = ia_r + ADDR_W'(1);
                case (prog_rdata)
                  OP_RIGHT: dp_nxt = dp_r + DP_W'(1);
                  OP_LEFT:  dp_nxt = dp_r - DP_W'(1);
                  OP_INC: begin
                    tape_req.wr_en   = 1'b1;
                    tape_req.wr_data = cell_q + 8'd1;
                  end
                  OP_DEC: begin
                    tape_req.wr_en   = 1'b1;
                    tape_req.wr_data = cell_q - 8'd1;
                  end
                  OP_IN: begin
                    tape_req.wr_en   = 1'b1;
                    tape_req.wr_data = ib_r;
                  end
                  OP_OUT: begin
                    oval_nxt  = 1'b1;
                    obyte_nxt = cell_q;
                  end
                  OP_OPEN: begin
                    if (cell_q != 8'd0) begin
                      if (depth_r >= DEPTH_W'(STACK_DEPTH)) begin
                        hcode_nxt = ST_OVERFLOW;
                        ia_nxt    = ia_r;
                        step_done = 1'b0;
                      end else begin
                        stk_we    = 1'b1;
                        depth_nxt = depth_r + DEPTH_W'(1);
                      end
                    end else begin
                      // forward skip: scan for the matching close
                      emit       = 1'b0;
                      step_done  = 1'b0;
                      ia_nxt     = ia_r;
                      scan_nxt   = ia_r + ADDR_W'(1);
                      nest_nxt   = '0;
                      prog_re    = 1'b1;
                      prog_raddr = scan_nxt[PA_W-1:0];
                      state_nxt  = S_SCAN;
                    end
                  end
                  OP_CLOSE: begin
                    if (depth_r == '0) begin
                      hcode_nxt = ST_UNM_CLS;
                      ia_nxt    = ia_r;
                      step_done = 1'b0;
                    end else if (cell_q != 8'd0) begin
                      ia_nxt = {1'b0, stk_rdata} + ADDR_W'(1);
                    end else begin
                      depth_nxt = depth_m1;
                    end
                  end
                  default: ;
                endcase
              end
            end
            default: ;
          endcase
          if (emit) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (scan_r >= end_w) begin
          if (can_emit) begin
            hcode_nxt = ST_UNM_OPN;
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (prog_rdata == OP_CLOSE && nest_r == '0) begin
          if (can_emit) begin
            ia_nxt    = scan_r + ADDR_W'(1);
            step_done = 1'b1;
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          if (prog_rdata == OP_OPEN) begin
            nest_nxt = nest_r + ADDR_W'(1);
          end else if (prog_rdata == OP_CLOSE) begin
            nest_nxt = nest_r - ADDR_W'(1);
          end
          scan_nxt   = scan_r + ADDR_W'(1);
          prog_re    = 1'b1;
          prog_raddr = scan_nxt[PA_W-1:0];
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // reaching the end with open loops is an unmatched open
    if (step_done && ia_nxt >= end_w && depth_nxt != '0) begin
      hcode_nxt = ST_UNM_OPN;
    end

    if (hcode_nxt != ST_RUN) begin
      status_w = hcode_nxt;
    end else begin
      status_w = (ia_nxt >= end_w) ? ST_FINISHED : ST_RUN;
    end

    ovld_nxt  = ovld_r && !out_ch.ready;
    ostat_nxt = ostat_r;
    oaddr_nxt = oaddr_r;
    if (!emit) begin
      oval_nxt  = oval_r;
      obyte_nxt = obyte_r;
    end else begin
      ovld_nxt  = 1'b1;
      ostat_nxt = status_w;
      oaddr_nxt = ia_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dp_r    <= '0;
      ia_r    <= '0;
      depth_r <= '0;
      hcode_r <= ST_RUN;
      len_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dp_r    <= dp_nxt;
      ia_r    <= ia_nxt;
      depth_r <= depth_nxt;
      hcode_r <= hcode_nxt;
      ovld_r  <= ovld_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      cmd_r <= in_ch.cmd;
      pa_r  <= in_ch.prog_addr;
      pb_r  <= in_ch.prog_byte;
      ib_r  <= in_ch.in_byte;
    end
    scan_r  <= scan_nxt;
    nest_r  <= nest_nxt;
    oval_r  <= oval_nxt;
    obyte_r <= obyte_nxt;
    ostat_r <= ostat_nxt;
    oaddr_r <= oaddr_nxt;
  end

  assign out_ch.valid     = ovld_r;
  assign out_ch.out_valid = oval_r;
  assign out_ch.out_byte  = obyte_r;
  assign out_ch.status    = ostat_r;
  assign out_ch.next_addr = oaddr_r;

endmodule

FILE: hdl/tmi_checker.sv
// ----------------------------------------------------------------------------
// tmi_checker: port-level checks
// Watches the item channels of the interpreter top level.
// ----------------------------------------------------------------------------
module tmi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_vld,
  input logic        out_rdy,
  input logic        out_valid,
  input logic [7:0]  out_byte,
  input logic [2:0]  status,
  input logic [10:0] next_addr
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld && $stable(out_byte) && $stable(status))
    else $error("result changed while stalled");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_valid |-> out_byte == 8'd0)
    else $error("out_byte set without output");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> status <= 3'd4 && next_addr <= 11'd1024)
    else $error("status or next_addr out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while one is in flight");

endmodule

bind tape_machine_interpreter_top tmi_checker u_tmi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_vld   (out_ch.valid),
  .out_rdy   (out_ch.ready),
  .out_valid (out_ch.out_valid),
  .out_byte  (out_ch.out_byte),
  .status    (out_ch.status),
  .next_addr (out_ch.next_addr)
);
